FILE: sv/edre_pkg.sv
// ----------------------------------------------------------------------------
// edre_pkg: shared constants for the erosion depth ridge extractor
// Command codes, map geometry and register indexes.
// ----------------------------------------------------------------------------
package edre_pkg;
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int AW = CW + RW;
	localparam int DIMW = 9;
	localparam logic [7:0] DEPTH_CAP = 8'd255;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_RUN    = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// one memory word: map bit, depth, scratch/ridge bit
	typedef struct packed {
		logic       map;
		logic [7:0] depth;
		logic       flag;
	} cell_t;
endpackage

FILE: sv/erosion_depth_ridge_extractor.sv
// ----------------------------------------------------------------------------
// erosion_depth_ridge_extractor
// Peels a binary map in passes, records removal depth and depth ridges.
// ----------------------------------------------------------------------------
// channel | signals                            | dir
// in      | valid ready kind row col pixel_value | in
// out     | out_valid out_ready depth ridge pass_count | out
// cfg     | cfg_we cfg_index cfg_data          | in
//
// Load: read the word, write it back with the new map bit. Read: read the word, then
// register depth, ridge and pass count on the output. Run: one clear sweep of the
// map (read, wait, write per word), then per pass a decide and a commit sweep of the
// interior (nine reads, one write per pixel on one memory port), then a ridge sweep.
// Reset clears control only; the map memory holds garbage until loaded.
// Input is refused while a word waits on the output or a command runs.
module erosion_depth_ridge_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       valid,
	output logic       ready,
	input  logic [1:0] kind,
	input  logic [7:0] row,
	input  logic [7:0] col,
	input  logic       pixel_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] depth,
	output logic       ridge,
	output logic [7:0] pass_count
);
	localparam int AW = edre_pkg::AW;
	localparam int CW = edre_pkg::CW;
	localparam int RW = edre_pkg::RW;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_CLEAR = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;
	localparam logic [2:0] ST_RDATA = 3'd4;

	localparam logic [1:0] PH_DECIDE = 2'd0;
	localparam logic [1:0] PH_COMMIT = 2'd1;
	localparam logic [1:0] PH_RIDGE  = 2'd2;

	edre_pkg::cell_t mem [1 << AW];
	edre_pkg::cell_t rd_q;
	logic [AW-1:0] raddr;
	logic          re;
	logic [AW-1:0] waddr;
	logic          we;
	edre_pkg::cell_t wdata;

	logic [8:0] width_q, height_q;
	logic [8:0] w_eff, h_eff;
	logic [2:0] state_q;
	logic [1:0] phase_q;
	logic [3:0] step_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic [7:0] pass_q, total_q;
	logic       removed_q;
	logic       inside_q;
	logic       pixel_q;
	logic [1:0] clr_ph_q;
	// gathered neighborhood
	edre_pkg::cell_t ctr_q;
	logic       edge_q;
	logic [7:0] nd_q [8];
	logic [7:0] pass_next;

	always_comb begin
		if (width_q < 9'd3) w_eff = 9'd3;
		else if (width_q > 9'(edre_pkg::MAX_WIDTH)) w_eff = 9'(edre_pkg::MAX_WIDTH);
		else w_eff = width_q;
		if (height_q < 9'd3) h_eff = 9'd3;
		else if (height_q > 9'(edre_pkg::MAX_HEIGHT)) h_eff = 9'(edre_pkg::MAX_HEIGHT);
		else h_eff = height_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	function automatic logic alive(edre_pkg::cell_t x);
		return x.map && (x.depth == 8'd0);
	endfunction

	function automatic logic peak(logic [7:0] d, logic [7:0] a, logic [7:0] b);
		return d >= a && d >= b && !(d == a && d == b);
	endfunction

	// neighbor offsets by step 1..8; step 0 reads center
	logic [RW-1:0] nr;
	logic [CW-1:0] nc;
	always_comb begin
		nr = r_q;
		nc = c_q;
		unique case (step_q)
			4'd1: begin nr = r_q - 1'b1; nc = c_q - 1'b1; end
			4'd2: begin nr = r_q - 1'b1; end
			4'd3: begin nr = r_q - 1'b1; nc = c_q + 1'b1; end
			4'd4: begin nc = c_q - 1'b1; end
			4'd5: begin nc = c_q + 1'b1; end
			4'd6: begin nr = r_q + 1'b1; nc = c_q - 1'b1; end
			4'd7: begin nr = r_q + 1'b1; end
			4'd8: begin nr = r_q + 1'b1; nc = c_q + 1'b1; end
			default: begin end
		endcase
	end

	logic last_col, last_row;
	assign last_col = ({1'b0, c_q} == w_eff - 9'd2);
	assign last_row = ({1'b0, r_q} == h_eff - 9'd2);
	assign pass_next = (pass_q == edre_pkg::DEPTH_CAP) ? pass_q : pass_q + 8'd1;
	assign ready = (state_q == ST_IDLE) && !out_valid;

	// ridge test on gathered depths: order NW N NE W E SW S SE
	logic rg;
	assign rg = peak(ctr_q.depth, nd_q[0], nd_q[7]) || peak(ctr_q.depth, nd_q[1], nd_q[6])
		|| peak(ctr_q.depth, nd_q[2], nd_q[5]) || peak(ctr_q.depth, nd_q[4], nd_q[3]);

	always_comb begin
		re = 1'b0;
		raddr = {r_q, c_q};
		we = 1'b0;
		waddr = {r_q, c_q};
		wdata = ctr_q;
		unique case (state_q)
			ST_IDLE: begin
				raddr = {row, col};
				re = valid && ready && (kind == edre_pkg::KIND_LOAD || kind == edre_pkg::KIND_READ);
			end
			ST_READ: begin
				we = inside_q;
				wdata = rd_q;
				wdata.map = pixel_q;
			end
			ST_CLEAR: begin
				re = (clr_ph_q == 2'd0);
				we = (clr_ph_q == 2'd2);
				wdata.map = rd_q.map;
				wdata.depth = 8'd0;
				wdata.flag = 1'b0;
			end
			ST_SWEEP: begin
				raddr = {nr, nc};
				re = (step_q <= 4'd8);
				if (step_q == 4'd10) begin
					we = 1'b1;
					wdata = ctr_q;
					unique case (phase_q)
						PH_DECIDE: wdata.flag = alive(ctr_q) && edge_q;
						PH_COMMIT: begin
							wdata.flag = 1'b0;
							if (ctr_q.flag) wdata.depth = pass_next;
						end
						default: wdata.flag = rg;
					endcase
				end
			end
			default: begin end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256;
			height_q <= 9'd256;
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			total_q <= 8'd0;
			pass_q <= 8'd0;
			step_q <= 4'd0;
			phase_q <= PH_DECIDE;
			removed_q <= 1'b0;
			clr_ph_q <= 2'd0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == edre_pkg::REG_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (valid && ready) begin
						inside_q <= ({1'b0, row} < h_eff) && ({1'b0, col} < w_eff);
						pixel_q <= pixel_value;
						r_q <= (kind == edre_pkg::KIND_RUN) ? '0 : row;
						c_q <= (kind == edre_pkg::KIND_RUN) ? '0 : col;
						if (kind == edre_pkg::KIND_LOAD || kind == edre_pkg::KIND_READ)
							state_q <= (kind == edre_pkg::KIND_LOAD) ? ST_READ : ST_RDATA;
						else if (kind == edre_pkg::KIND_RUN) begin
							clr_ph_q <= 2'd0;
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_READ: begin
					// write done if inside the map (new map bit stored, old depth/flag kept)
					state_q <= ST_IDLE;
				end
				ST_RDATA: begin
					depth <= inside_q ? rd_q.depth : 8'd0;
					ridge <= inside_q ? rd_q.flag : 1'b0;
					pass_count <= total_q;
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_CLEAR: begin
					// clr_ph 0 issues read, 1 waits, 2 writes
					if (clr_ph_q == 2'd2) begin
						clr_ph_q <= 2'd0;
						if ({1'b0, c_q} == w_eff - 9'd1) begin
							if ({1'b0, r_q} == h_eff - 9'd1) begin
								r_q <= RW'(1);
								c_q <= CW'(1);
								step_q <= 4'd0;
								phase_q <= PH_DECIDE;
								removed_q <= 1'b0;
								pass_q <= 8'd0;
								state_q <= ST_SWEEP;
							end else begin
								c_q <= '0;
								r_q <= r_q + 1'b1;
							end
						end else c_q <= c_q + 1'b1;
					end else clr_ph_q <= clr_ph_q + 2'd1;
				end
				ST_SWEEP: begin
					// data for step k-1 read arrives at step k
					if (step_q >= 4'd1 && step_q <= 4'd9) begin
						if (step_q == 4'd1) begin
							ctr_q <= rd_q;
							edge_q <= 1'b0;
						end else begin
							nd_q[3'(step_q - 4'd2)] <= rd_q.depth;
							if (!alive(rd_q)) edge_q <= 1'b1;
						end
					end
					if (step_q == 4'd10) begin
						step_q <= 4'd0;
						if (phase_q == PH_DECIDE && alive(ctr_q) && edge_q) removed_q <= 1'b1;
						if (last_col) begin
							c_q <= CW'(1);
							if (last_row) begin
								r_q <= RW'(1);
								unique case (phase_q)
									PH_DECIDE: begin
										if (removed_q || (alive(ctr_q) && edge_q)) begin
											phase_q <= PH_COMMIT;
										end else begin
											total_q <= pass_q;
											phase_q <= PH_RIDGE;
										end
									end
									PH_COMMIT: begin
										pass_q <= pass_next;
										removed_q <= 1'b0;
										phase_q <= PH_DECIDE;
									end
									default: state_q <= ST_IDLE;
								endcase
							end else r_q <= r_q + 1'b1;
						end else c_q <= c_q + 1'b1;
					end else step_q <= step_q + 4'd1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
